// ===== hw/rtl/rxd_pkg.sv =====
// Shared types and constants of the run-length XOR delta frame decoder.
`default_nettype none

package rxd_pkg;

    localparam logic [3:0]  BYTE_BITS          = 4'd8;
    localparam logic [3:0]  LIT_BITS           = 4'd5;
    localparam logic [3:0]  RUN_BITS           = 4'd10;
    localparam logic [5:0]  RUN_BIAS           = 6'd2;
    localparam logic [15:0] FRAME_PIXELS_RESET = 16'd19200;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SHIFT,
        T_RUN,
        T_FLUSH
    } top_state_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_WRITE
    } emit_state_t;

    // Token found by the bit-serial parser in the current cycle.
    typedef struct packed {
        logic       fire;
        logic [3:0] value;
        logic [5:0] reps;
        logic       last_bit;
        logic       empty;
    } tok_t;

    // Status of the pixel emitter toward the sequencer.
    typedef struct packed {
        logic busy;
        logic frame_end;
        logic flush_done;
        logic pos_lt_lim;
    } em_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rle_xor_delta_frame_decoder.sv =====
// Top level of the run-length XOR delta frame decoder.
//
// Compressed bytes enter on the s_axis channel, one request per byte; tuser bit 0
// is frame_start and bit 1 is first_in_sequence. Each byte is shifted through the
// token parser one bit per cycle, MSB first, but halts while a token is emitted.
// A literal token yields one pixel and a run token yields count+2 pixels. Every
// pixel is XORed with the stored reference pixel, written back to the reference
// memory and sent on m_axis, one request per pixel: tdata carries the pixel and
// its index, tlast marks the final pixel of the frame and tuser marks the last
// pixel caused by the input byte. Without stalls a byte passes through these
// steps: the accept, eight bits of shifting, a reference read and a write-back
// for each pixel, a resume of the shifting for each token and the release of
// the last pixel. A token that ends the frame skips its resume step and the
// bits after it; a byte that is ignored goes no further than its accept step.
// A new byte is taken only after the previous one is finished. The newest pixel
// waits in a hold stage until the next one is known, so that its byte-end flag
// is right; an output register lets decoding go on while the receiver stalls,
// and the decoder waits only when both stages are full. Reset clears the token
// state, ends any frame and makes the reference read as zero; frame_pixels
// returns to 19200.
`default_nettype none

module rle_xor_delta_frame_decoder #(
    parameter int MAX_FRAME_PIXELS = 32768,
    localparam int PW = $clog2(MAX_FRAME_PIXELS + 1),
    localparam int CW = (PW > 16) ? PW : 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,       // frame_pixels
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] compressed_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] frame_start, [1] first_in_sequence
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [3:0] pixel, [18:4] pixel_index, rest zero
    output logic             m_axis_tlast,   // frame_done
    output logic             m_axis_tuser    // last
);

    rxd_pkg::top_state_t state_reg, state_next;
    logic [15:0] frame_pixels_reg;
    logic        active_reg, active_next;
    logic        zero_ref_reg, zero_ref_next;

    logic [CW-1:0] lim;
    logic          in_fire;
    logic          frame_start;
    logic          live;
    logic          parser_load;
    logic          parser_clear;
    logic          parser_step;
    logic          run_start;
    logic          flush;
    logic          frame_begin;
    rxd_pkg::tok_t       tok;
    rxd_pkg::em_status_t st;

    logic [3:0]  out_pixel;
    logic [14:0] out_index;

    // Lengths above the memory depth act as the memory depth.
    assign lim = (CW'(frame_pixels_reg) > CW'(MAX_FRAME_PIXELS)) ?
                 CW'(MAX_FRAME_PIXELS) : CW'(frame_pixels_reg);

    assign s_axis_tready = (state_reg == rxd_pkg::T_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign frame_start   = s_axis_tuser[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= rxd_pkg::FRAME_PIXELS_RESET;
        end
        else if (cfg_we)
        begin
            frame_pixels_reg <= cfg_data;
        end
    end

    rxd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (parser_load),
        .clear   (parser_clear),
        .byte_in (s_axis_tdata),
        .step    (parser_step),
        .tok     (tok)
    );

    rxd_emitter #(
        .DEPTH (MAX_FRAME_PIXELS)
    ) u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_begin (frame_begin),
        .zero_ref    (zero_ref_reg),
        .lim         (lim),
        .run_start   (run_start),
        .run_value   (tok.value),
        .run_reps    (tok.reps),
        .flush       (flush),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_pixel   (out_pixel),
        .out_index   (out_index),
        .out_done    (m_axis_tlast),
        .out_last    (m_axis_tuser),
        .status      (st)
    );

    assign m_axis_tdata = {5'd0, out_index, out_pixel};

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        zero_ref_next = zero_ref_reg;
        parser_load   = 1'b0;
        parser_clear  = 1'b0;
        parser_step   = 1'b0;
        run_start     = 1'b0;
        flush         = 1'b0;
        frame_begin   = 1'b0;
        live          = 1'b0;

        case (state_reg)
            rxd_pkg::T_IDLE:
            begin
                if (in_fire)
                begin
                    // A frame start rewinds to pixel zero before the byte is decoded.
                    if (frame_start)
                    begin
                        frame_begin   = 1'b1;
                        parser_clear  = 1'b1;
                        zero_ref_next = s_axis_tuser[1];
                        live          = (lim != '0);
                    end
                    else
                    begin
                        live = active_reg && st.pos_lt_lim;
                    end
                    active_next = live;
                    if (live)
                    begin
                        parser_load = 1'b1;
                        state_next  = rxd_pkg::T_SHIFT;
                    end
                end
            end

            rxd_pkg::T_SHIFT:
            begin
                parser_step = 1'b1;
                if (tok.fire)
                begin
                    run_start  = 1'b1;
                    state_next = rxd_pkg::T_RUN;
                end
                else if (tok.last_bit)
                begin
                    state_next = rxd_pkg::T_FLUSH;
                end
            end

            rxd_pkg::T_RUN:
            begin
                // The frame limit ends the frame and drops the rest of the byte.
                if (st.frame_end)
                begin
                    active_next = 1'b0;
                    state_next  = rxd_pkg::T_FLUSH;
                end
                else if (!st.busy)
                begin
                    state_next = tok.empty ? rxd_pkg::T_FLUSH : rxd_pkg::T_SHIFT;
                end
            end

            rxd_pkg::T_FLUSH:
            begin
                flush = 1'b1;
                if (st.flush_done)
                begin
                    state_next = rxd_pkg::T_IDLE;
                end
            end

            default:
            begin
                state_next = rxd_pkg::T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rxd_pkg::T_IDLE;
            active_reg   <= 1'b0;
            zero_ref_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            zero_ref_reg <= zero_ref_next;
        end
    end

    // The emitter only works while a run is being handed out.
    a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        st.busy |-> (state_reg == rxd_pkg::T_RUN))
        else $error("emitter busy outside of a run");

    // Reaching the frame limit closes the frame.
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rxd_pkg::T_RUN) && st.frame_end) |=> !active_reg)
        else $error("frame still active after its last pixel");

    // A frame opens only on a byte that carries frame_start.
    a_open_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(in_fire && frame_start))
        else $error("frame opened without frame_start");

endmodule

`default_nettype wire

// ===== hw/rtl/rxd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rxd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32768,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rxd_parser.sv =====
// Bit-serial token parser: shifts one compressed bit per cycle into the token while step is set.
`default_nettype none

module rxd_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic        clear,
    input  wire logic [7:0]  byte_in,
    input  wire logic        step,
    output rxd_pkg::tok_t    tok
);

    logic [7:0] byte_reg, byte_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic [8:0] pend_reg, pend_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [9:0] shifted;
    logic [3:0] cnt_inc;
    logic       is_lit;
    logic       is_run;

    assign shifted = {pend_reg, byte_reg[7]};
    assign cnt_inc = cnt_reg + 4'd1;
    assign is_lit  = (cnt_inc == rxd_pkg::LIT_BITS) && !shifted[4];
    assign is_run  = (cnt_inc >= rxd_pkg::RUN_BITS);

    always_comb
    begin
        tok.fire     = step && (is_lit || is_run);
        tok.value    = is_lit ? shifted[3:0] : shifted[8:5];
        tok.reps     = is_lit ? 6'd1 : ({1'b0, shifted[4:0]} + rxd_pkg::RUN_BIAS);
        tok.last_bit = (bits_left_reg == 4'd1);
        tok.empty    = (bits_left_reg == 4'd0);
    end

    always_comb
    begin
        byte_next      = byte_reg;
        bits_left_next = bits_left_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        if (load)
        begin
            byte_next      = byte_in;
            bits_left_next = rxd_pkg::BYTE_BITS;
        end
        else if (step)
        begin
            byte_next      = {byte_reg[6:0], 1'b0};
            bits_left_next = bits_left_reg - 4'd1;
            if (is_lit || is_run)
            begin
                pend_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                pend_next = shifted[8:0];
                cnt_next  = cnt_inc;
            end
        end
        if (clear)
        begin
            pend_next = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_left_reg <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            bits_left_reg <= bits_left_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rxd_emitter.sv =====
// Pixel emitter: reference read, XOR, write-back, one-pixel hold and output register.
`default_nettype none

module rxd_emitter #(
    parameter int DEPTH = 32768,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int PW = $clog2(DEPTH + 1),
    localparam int CW = (PW > 16) ? PW : 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          frame_begin,
    input  wire logic          zero_ref,
    input  wire logic [CW-1:0] lim,
    input  wire logic          run_start,
    input  wire logic [3:0]    run_value,
    input  wire logic [5:0]    run_reps,
    input  wire logic          flush,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [3:0]         out_pixel,
    output logic [14:0]        out_index,
    output logic               out_done,
    output logic               out_last,
    output rxd_pkg::em_status_t status
);

    rxd_pkg::emit_state_t state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [3:0]    val_reg, val_next;
    logic [5:0]    reps_reg, reps_next;
    logic          hold_valid_reg, hold_valid_next;
    logic [3:0]    hold_pix_reg, hold_pix_next;
    logic [14:0]   hold_idx_reg, hold_idx_next;
    logic          hold_done_reg, hold_done_next;
    logic          out_valid_reg, out_valid_next;
    logic [3:0]    out_pix_reg, out_pix_next;
    logic [14:0]   out_idx_reg, out_idx_next;
    logic          out_done_reg, out_done_next;
    logic          out_last_reg, out_last_next;

    logic [PW-1:0]    pos_inc;
    logic             pos_lt_lim;
    logic             done_n;
    logic             out_free;
    logic             push;
    logic             push_last;
    logic             ram_we;
    logic             ram_re;
    logic [3:0]       rd_data;
    logic [3:0]       pix;

    assign pos_inc    = pos_reg + 1'b1;
    assign pos_lt_lim = CW'(pos_reg) < lim;
    assign done_n     = CW'(pos_inc) == lim;
    assign out_free   = !out_valid_reg || out_ready;
    assign pix        = val_reg ^ (zero_ref ? 4'd0 : rd_data);

    rxd_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_ref (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (pix),
        .re    (ram_re),
        .raddr (pos_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        reps_next       = reps_reg;
        hold_valid_next = hold_valid_reg;
        hold_pix_next   = hold_pix_reg;
        hold_idx_next   = hold_idx_reg;
        hold_done_next  = hold_done_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        status          = '0;
        status.pos_lt_lim = pos_lt_lim;

        case (state_reg)
            rxd_pkg::E_IDLE:
            begin
                if (frame_begin)
                begin
                    pos_next = '0;
                end
                if (run_start)
                begin
                    val_next   = run_value;
                    reps_next  = run_reps;
                    state_next = rxd_pkg::E_READ;
                end
                else if (flush)
                begin
                    if (!hold_valid_reg)
                    begin
                        status.flush_done = 1'b1;
                    end
                    else if (out_free)
                    begin
                        push              = 1'b1;
                        push_last         = 1'b1;
                        hold_valid_next   = 1'b0;
                        status.flush_done = 1'b1;
                    end
                end
            end

            rxd_pkg::E_READ:
            begin
                status.busy = 1'b1;
                if (pos_lt_lim)
                begin
                    ram_re     = 1'b1;
                    state_next = rxd_pkg::E_WRITE;
                end
                else
                begin
                    status.frame_end = 1'b1;
                    state_next       = rxd_pkg::E_IDLE;
                end
            end

            rxd_pkg::E_WRITE:
            begin
                status.busy = 1'b1;
                if (!hold_valid_reg || out_free)
                begin
                    ram_we          = 1'b1;
                    push            = hold_valid_reg;
                    hold_valid_next = 1'b1;
                    hold_pix_next   = pix;
                    hold_idx_next   = 15'(pos_reg);
                    hold_done_next  = done_n;
                    pos_next        = pos_inc;
                    reps_next       = reps_reg - 6'd1;
                    if (CW'(pos_inc) >= lim)
                    begin
                        status.frame_end = 1'b1;
                        state_next       = rxd_pkg::E_IDLE;
                    end
                    else if (reps_reg == 6'd1)
                    begin
                        state_next = rxd_pkg::E_IDLE;
                    end
                    else
                    begin
                        state_next = rxd_pkg::E_READ;
                    end
                end
            end

            default:
            begin
                state_next = rxd_pkg::E_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_idx_next   = out_idx_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = hold_pix_reg;
            out_idx_next   = hold_idx_reg;
            out_done_next  = hold_done_reg;
            out_last_next  = push_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rxd_pkg::E_IDLE;
            pos_reg        <= '0;
            reps_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            reps_reg       <= reps_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        hold_pix_reg  <= hold_pix_next;
        hold_idx_reg  <= hold_idx_next;
        hold_done_reg <= hold_done_next;
        out_pix_reg   <= out_pix_next;
        out_idx_reg   <= out_idx_next;
        out_done_reg  <= out_done_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pix_reg;
    assign out_index = out_idx_reg;
    assign out_done  = out_done_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/rle_xor_delta_frame_decoder_test.sv =====
// Self-checking testbench for the run-length XOR delta frame decoder.
module rle_xor_delta_frame_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PIXELS = 32768;

    // One pixel as the block should send it on the master side.
    typedef struct packed {
        logic [3:0]  pixel;
        logic [14:0] index;
        logic        done;
        logic        last;
    } px_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    rle_xor_delta_frame_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // The watchdog covers the slowest legal run several times over.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder shadow state. It mirrors the block: a token shift register,
    // the pixel position in the current frame and a copy of the reference
    // frame. written_hi tracks how far the stored frame has been written,
    // which is always a prefix starting at pixel 0, so that a frame that
    // keeps the stored reference never reads an entry nobody has written.
    // ------------------------------------------------------------------
    logic [15:0] frame_len;
    logic [9:0]  tok_bits;
    logic [3:0]  tok_len;
    int unsigned next_pos;
    bit          in_frame;
    bit          zero_ref;
    int unsigned written_hi;
    logic [3:0]  pixel_store [0:MAX_PIXELS-1];

    px_result_t  byte_pixels[$];
    px_result_t  expected_pixels[$];

    // Run statistics and error bookkeeping.
    int unsigned bytes_sent;
    int unsigned bytes_decoded;
    int unsigned frames_started;
    int unsigned settings_used;
    int unsigned pixels_checked;
    int unsigned error_count;

    // Idling controls for the two sides of the block.
    bit src_gaps;
    bit sink_stalls;
    int sink_hold;

    // Token bits waiting to be packed into bytes, MSB first.
    bit stream_bits[$];

    // Lengths above the memory size behave as the memory size.
    function automatic int unsigned eff_len();
        return (frame_len > MAX_PIXELS) ? MAX_PIXELS : int'(frame_len);
    endfunction

    // Emits one decoded value if the frame still has room; the stored pixel
    // is replaced by the reconstructed one.
    function automatic void put_pixel(input logic [3:0] value);
        int unsigned lim;
        logic [3:0]  ref_val;
        px_result_t  item;
        lim = eff_len();
        if (!in_frame || next_pos >= lim) begin
            in_frame = 1'b0;
            return;
        end
        ref_val = zero_ref ? 4'h0 : pixel_store[next_pos];
        item.pixel = value ^ ref_val;
        item.index = next_pos[14:0];
        item.done  = (next_pos + 1 == lim);
        item.last  = 1'b0;
        pixel_store[next_pos] = item.pixel;
        byte_pixels.push_back(item);
        next_pos++;
        if (next_pos > written_hi)
            written_hi = next_pos;
        if (next_pos >= lim)
            in_frame = 1'b0;
    endfunction

    // Works out every pixel that one compressed byte releases.
    function automatic void decode_byte(input logic [7:0] data, input bit fs, input bit fis);
        logic [3:0] run_value;
        int         reps;
        if (fs) begin
            next_pos = 0;
            tok_bits = '0;
            tok_len  = '0;
            in_frame = 1'b1;
            zero_ref = fis;
            frames_started++;
        end
        if (in_frame && next_pos >= eff_len())
            in_frame = 1'b0;
        if (!in_frame)
            return;
        bytes_decoded++;
        byte_pixels.delete();
        for (int i = 7; i >= 0 && in_frame; i--) begin
            tok_bits = {tok_bits[8:0], data[i]};
            tok_len++;
            if (tok_len == 4'd5 && !tok_bits[4]) begin
                // Literal token: a zero flag bit and four value bits.
                put_pixel(tok_bits[3:0]);
                tok_bits = '0;
                tok_len  = '0;
            end else if (tok_len >= 4'd10) begin
                // Run token: flag, four value bits, five count bits.
                run_value = tok_bits[8:5];
                reps = int'(tok_bits[4:0]) + 2;
                tok_bits = '0;
                tok_len  = '0;
                for (int k = 0; k < reps && in_frame; k++)
                    put_pixel(run_value);
            end
        end
        if (byte_pixels.size() != 0)
            byte_pixels[byte_pixels.size() - 1].last = 1'b1;
        foreach (byte_pixels[j])
            expected_pixels.push_back(byte_pixels[j]);
    endfunction

    // ------------------------------------------------------------------
    // Random timing helpers: mostly short gaps, now and then a long one.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // The receiver drops tready for random stretches while sink_stalls is set.
    always @(posedge clk) begin
        if (sink_hold != 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_stalls && $urandom_range(0, 99) < 15) begin
            m_axis_tready <= 1'b0;
            sink_hold <= pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void log_error(input string what, input int unsigned want,
                                      input int unsigned got);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Every pixel request taken from the block is compared with the oldest
    // pixel still expected, one field at a time.
    always @(posedge clk) begin
        px_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                log_error("pixel with none pending, index", 0, m_axis_tdata[18:4]);
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_axis_tdata[3:0] !== want.pixel)
                    log_error("pixel value", want.pixel, m_axis_tdata[3:0]);
                if (m_axis_tdata[18:4] !== want.index)
                    log_error("pixel index", want.index, m_axis_tdata[18:4]);
                if (m_axis_tlast !== want.done)
                    log_error("frame_done flag", want.done, m_axis_tlast);
                if (m_axis_tuser !== want.last)
                    log_error("byte-end flag", want.last, m_axis_tuser);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks.
    // ------------------------------------------------------------------

    // Sends one compressed byte as one request. A frame that keeps the stored
    // reference must fit inside what has been written so far; where it would
    // not, the byte is turned into a fresh frame with the reference forced to
    // zero.
    task automatic send_byte(input logic [7:0] data, input bit fs, input bit fis);
        int gap;
        if (fs && !fis && eff_len() > written_hi)
            fis = 1'b1;
        if (!fs && in_frame && !zero_ref && eff_len() > written_hi) begin
            fs  = 1'b1;
            fis = 1'b1;
        end
        decode_byte(data, fs, fis);
        bytes_sent++;
        gap = src_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {fis, fs};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Lets everything drain: no request offered, every expected pixel taken,
    // and then enough cycles for a byte that releases no pixel to finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_frame_len(input logic [15:0] len);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        frame_len = len;
        settings_used++;
    endtask

    function automatic void add_bits(input int unsigned value, input int width);
        for (int i = width - 1; i >= 0; i--)
            stream_bits.push_back(value[i]);
    endfunction

    function automatic void add_literal(input logic [3:0] value);
        add_bits(0, 1);
        add_bits(value, 4);
    endfunction

    function automatic void add_run(input logic [3:0] value, input logic [4:0] count);
        add_bits(1, 1);
        add_bits(value, 4);
        add_bits(count, 5);
    endfunction

    function automatic void add_random_token();
        if ($urandom_range(0, 1))
            add_literal(4'($urandom_range(0, 15)));
        else if ($urandom_range(0, 9) < 7)
            add_run(4'($urandom_range(0, 15)), 5'($urandom_range(0, 7)));
        else
            add_run(4'($urandom_range(0, 15)), 5'($urandom_range(8, 31)));
    endfunction

    // Packs the queued token bits into bytes, padding the tail with zeros,
    // and sends them; only the first byte carries the frame flags.
    task automatic send_stream(input bit fs, input bit fis);
        logic [7:0] data;
        bit         first;
        first = 1'b1;
        while (stream_bits.size() != 0) begin
            data = 8'h00;
            for (int i = 7; i >= 0; i--)
                if (stream_bits.size() != 0)
                    data[i] = stream_bits.pop_front();
            send_byte(data, first && fs, first && fis);
            first = 1'b0;
        end
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 16'($urandom_range(1, 48));
        if (r < 85)
            return 16'($urandom_range(49, 400));
        if (r < 90)
            return 16'd0;
        if (r < 95)
            return 16'($urandom_range(32768, 65535));
        return 16'd19200;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Length still at its reset value: literals, a short run, an all-ones byte
    // that leaves token bits pending and an all-zeros byte that finishes them.
    task automatic test_default_length();
        add_literal(4'h0);
        add_literal(4'hF);
        add_run(4'h5, 5'd0);
        send_stream(1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
    endtask

    // Shrinking the length below the current position ends the running frame,
    // and bytes without frame_start are then dropped.
    task automatic test_length_drop_mid_frame();
        write_frame_len(16'd2);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b1);
    endtask

    // A full frame with a zero reference whose last run is cut at the frame
    // end, a frame cut short after one pixel, and a full frame that reads
    // back both the new pixel and the untouched ones.
    task automatic test_literal_and_run_tokens();
        write_frame_len(16'd40);
        add_run(4'hA, 5'd31);
        add_literal(4'h3);
        add_run(4'h6, 5'd0);
        add_literal(4'h9);
        add_run(4'hC, 5'd5);
        send_stream(1'b1, 1'b1);
        add_literal(4'h7);
        send_stream(1'b1, 1'b0);
        add_run(4'hF, 5'd31);
        add_run(4'h0, 5'd5);
        send_stream(1'b1, 1'b0);
    endtask

    // A frame_start in the middle of a run token throws the pending bits away.
    task automatic test_restart_mid_token();
        send_byte(8'hC1, 1'b1, 1'b1);
        add_literal(4'h2);
        add_literal(4'hD);
        send_stream(1'b1, 1'b0);
    endtask

    // A one-pixel frame: the run is cut to a single pixel that also ends the
    // frame, and the following byte is ignored.
    task automatic test_single_pixel_frame();
        write_frame_len(16'd1);
        add_run(4'hB, 5'd31);
        send_stream(1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
    endtask

    // A zero length ends the frame before any pixel.
    task automatic test_zero_length_frame();
        write_frame_len(16'd0);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h55, 1'b0, 1'b0);
    endtask

    // A length beyond the memory size acts as the memory size.
    task automatic test_oversized_length();
        write_frame_len(16'hFFFF);
        add_run(4'h3, 5'd31);
        add_run(4'hE, 5'd31);
        send_stream(1'b1, 1'b1);
    endtask

    // Mostly well-formed frames with random tokens, sometimes cut short or
    // overrunning the length, mixed with stray bytes and length changes.
    task automatic test_random_frames();
        int unsigned start_bytes;
        int unsigned round;
        int          nbytes;
        start_bytes = bytes_sent;
        round = 0;
        while (bytes_sent - start_bytes < 133) begin
            if (round % 12 == 0) begin
                src_gaps    = $urandom_range(0, 3) != 0;
                sink_stalls = $urandom_range(0, 3) != 0;
            end
            round++;
            if ($urandom_range(0, 99) < 25)
                write_frame_len(pick_length());
            if ($urandom_range(0, 9) < 8) begin
                nbytes = $urandom_range(1, 10);
                while (stream_bits.size() < nbytes * 8)
                    add_random_token();
                while (stream_bits.size() > nbytes * 8)
                    void'(stream_bits.pop_back());
                send_stream(1'b1, 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        frame_len      = 16'd19200;
        tok_bits       = '0;
        tok_len        = '0;
        next_pos       = 0;
        in_frame       = 1'b0;
        zero_ref       = 1'b1;
        written_hi     = 0;
        bytes_sent     = 0;
        bytes_decoded  = 0;
        frames_started = 0;
        settings_used  = 0;
        pixels_checked = 0;
        error_count    = 0;
        src_gaps       = 1'b1;
        sink_stalls    = 1'b1;
        sink_hold      = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_length();
        test_length_drop_mid_frame();
        test_literal_and_run_tokens();
        test_restart_mid_token();
        test_single_pixel_frame();
        test_zero_length_frame();
        test_oversized_length();
        test_random_frames();
        wait_idle();

        $display("Sent %0d bytes, %0d of them decoded, checked %0d pixels in %0d frames,",
                 bytes_sent, bytes_decoded, pixels_checked, frames_started);
        $display("using %0d frame length writes including 0, 1 and 65535.", settings_used);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rxd_pkg.sv
hw/rtl/rxd_ram.sv
hw/rtl/rxd_parser.sv
hw/rtl/rxd_emitter.sv
hw/rtl/rle_xor_delta_frame_decoder.sv
tb/rle_xor_delta_frame_decoder_test.sv
